// ===== sv/idea_enc_pkg.sv =====
// Shared types, constants and modular arithmetic for the IDEA encryption engine.
package idea_enc_pkg;

   localparam int ROUNDS_DEFAULT = 8;
   localparam int KEYS_PER_ROUND = 6;
   localparam int OUT_KEYS       = 4;
   localparam int WORD_W         = 16;
   localparam int BLOCK_W        = 64;
   localparam int INDEX_W        = 6;

   typedef enum logic {
      CMD_LOAD    = 1'b0,
      CMD_ENCRYPT = 1'b1
   } command_type;

   typedef struct packed {
      logic                 enc_valid;
      logic                 key_wr;
      logic [INDEX_W-1:0]   key_index;
      logic [WORD_W-1:0]    key_value;
      logic [BLOCK_W-1:0]   block;
      logic                 last;
   } dispatch_type;

   typedef struct packed {
      logic ready;
      logic busy;
   } back_status_type;

   // Product of two IDEA words, a zero word standing for 65536.
   function automatic logic [32:0] mul_wide(input logic [15:0] x, input logic [15:0] y);
      logic [16:0] a;
      logic [16:0] b;
      logic [33:0] p;
      a = (x == 16'd0) ? 17'h10000 : {1'b0, x};
      b = (y == 16'd0) ? 17'h10000 : {1'b0, y};
      p = 34'(a) * 34'(b);
      return p[32:0];
   endfunction

   // Reduce modulo 65537 via 2^16 == -1; a result of 65536 wraps to zero.
   function automatic logic [15:0] mod_reduce(input logic [32:0] p);
      logic [17:0] d;
      d = {2'b00, p[15:0]} - {1'b0, p[32:16]};
      if (d[17]) begin
         d = d + 18'd65537;
      end
      return d[15:0];
   endfunction

endpackage

// ===== sv/idea_enc_front.sv =====
// Input queue and dispatcher: classifies requests into key loads and block encrypts.
module idea_enc_front
   import idea_enc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_command,
   input  logic [INDEX_W-1:0]   req_key_index,
   input  logic [WORD_W-1:0]    req_key_value,
   input  logic [BLOCK_W-1:0]   req_plain_block,
   input  logic                 req_last_block,
   input  back_status_type      status,
   output dispatch_type         dispatch
);

   typedef struct packed {
      logic                 cmd;
      logic [INDEX_W-1:0]   idx;
      logic [WORD_W-1:0]    val;
      logic [BLOCK_W-1:0]   blk;
      logic                 last;
   } entry_type;

   entry_type  q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   entry_type  head;
   logic       issue_enc, issue_load;

   assign req_full = (cnt_ff == 2'd2);
   assign push     = req_push && !req_full;
   assign head     = q_ff[rd_ptr_ff];

   always_comb begin
      issue_enc  = (cnt_ff != 2'd0) && (head.cmd == CMD_ENCRYPT) && status.ready;
      // hold a load until no block is in flight, so earlier blocks keep their keys
      issue_load = (cnt_ff != 2'd0) && (head.cmd == CMD_LOAD) && !status.busy;
      pop        = issue_enc || issue_load;
      wr_ptr_in  = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in     = cnt_ff + 2'(push) - 2'(pop);
      dispatch.enc_valid = issue_enc;
      dispatch.key_wr    = issue_load;
      dispatch.key_index = head.idx;
      dispatch.key_value = head.val;
      dispatch.block     = head.blk;
      dispatch.last      = head.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{cmd: req_command, idx: req_key_index, val: req_key_value,
                              blk: req_plain_block, last: req_last_block};
      end
   end

endmodule

// ===== sv/idea_enc_round.sv =====
// One IDEA round as a six-stage pipeline with a shared advance enable.
module idea_enc_round
   import idea_enc_pkg::*;
(
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic [KEYS_PER_ROUND-1:0][WORD_W-1:0] keys,
   input  logic                               in_valid,
   input  logic [BLOCK_W-1:0]                 in_blk,
   input  logic                               in_last,
   output logic                               out_valid,
   output logic [BLOCK_W-1:0]                 out_blk,
   output logic                               out_last,
   output logic                               busy
);

   logic [5:0]  v_ff;
   logic [5:0]  last_ff;
   logic [32:0] pa_ff, pd_ff, pt0_ff, pt1_ff;
   logic [15:0] a_ff, b1_ff, c1_ff, d_ff, b2_ff, c2_ff;
   logic [15:0] a3_ff, b3_ff, c3_ff, d3_ff;
   logic [15:0] a4_ff, b4_ff, c4_ff, d4_ff, t0_ff, s_ff;
   logic [15:0] a5_ff, b5_ff, c5_ff, d5_ff, t05_ff;
   logic [BLOCK_W-1:0] out_ff;
   logic [15:0] t1, t2;

   assign t1 = mod_reduce(pt1_ff);
   assign t2 = t05_ff + t1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_ff <= {last_ff[4:0], in_last};
         // stage 1: multiply outer words, add inner words
         pa_ff  <= mul_wide(in_blk[63:48], keys[0]);
         pd_ff  <= mul_wide(in_blk[15:0], keys[3]);
         b1_ff  <= in_blk[47:32] + keys[1];
         c1_ff  <= in_blk[31:16] + keys[2];
         // stage 2: reduce
         a_ff   <= mod_reduce(pa_ff);
         d_ff   <= mod_reduce(pd_ff);
         b2_ff  <= b1_ff;
         c2_ff  <= c1_ff;
         // stage 3: first multiply of the MA structure
         pt0_ff <= mul_wide(a_ff ^ c2_ff, keys[4]);
         a3_ff  <= a_ff;
         b3_ff  <= b2_ff;
         c3_ff  <= c2_ff;
         d3_ff  <= d_ff;
         // stage 4: reduce and mix
         t0_ff  <= mod_reduce(pt0_ff);
         s_ff   <= (b3_ff ^ d3_ff) + mod_reduce(pt0_ff);
         a4_ff  <= a3_ff;
         b4_ff  <= b3_ff;
         c4_ff  <= c3_ff;
         d4_ff  <= d3_ff;
         // stage 5: second multiply
         pt1_ff <= mul_wide(s_ff, keys[5]);
         t05_ff <= t0_ff;
         a5_ff  <= a4_ff;
         b5_ff  <= b4_ff;
         c5_ff  <= c4_ff;
         d5_ff  <= d4_ff;
         // stage 6: finish with middle words swapped
         out_ff <= {a5_ff ^ t1, c5_ff ^ t1, b5_ff ^ t2, d5_ff ^ t2};
      end
   end

   assign out_valid = v_ff[5];
   assign out_last  = last_ff[5];
   assign out_blk   = out_ff;
   assign busy      = |v_ff;

endmodule

// ===== sv/idea_enc_back.sv =====
// Subkey table, round pipeline, output transform and result queue.
module idea_enc_back
   import idea_enc_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEFAULT
)(
   input  logic                 clock,
   input  logic                 reset,
   input  dispatch_type         dispatch,
   output back_status_type      status,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [BLOCK_W-1:0]   rsp_cipher_block,
   output logic                 rsp_last_out
);

   localparam int KeyCount = KEYS_PER_ROUND * ROUNDS + OUT_KEYS;
   localparam int KeyW     = $clog2(KeyCount);
   localparam int OutBase  = KEYS_PER_ROUND * ROUNDS;

   logic [WORD_W-1:0]  key_ff [KeyCount];
   logic               en;
   logic [ROUNDS:0]    rv;
   logic [ROUNDS:0]    rl;
   logic [BLOCK_W-1:0] rb [ROUNDS+1];
   logic [ROUNDS-1:0]  rbusy;

   logic [1:0]         ov_ff;
   logic [1:0]         ol_ff;
   logic [32:0]        py0_ff, py3_ff;
   logic [15:0]        y1_ff, y2_ff;
   logic [BLOCK_W-1:0] oblk_ff;

   logic [BLOCK_W:0]   fifo_ff [2];
   logic               fwr_ff, frd_ff;
   logic [1:0]         fcnt_ff;
   logic               fpush, fpop, ffull;

   always_ff @(posedge clock) begin
      if (dispatch.key_wr && ({1'b0, dispatch.key_index} < 7'(KeyCount))) begin
         key_ff[dispatch.key_index[KeyW-1:0]] <= dispatch.key_value;
      end
   end

   assign ffull = (fcnt_ff == 2'd2);
   assign en    = !(ov_ff[1] && ffull);
   assign fpush = ov_ff[1] && !ffull;
   assign fpop  = rsp_pop && (fcnt_ff != 2'd0);

   assign rv[0] = dispatch.enc_valid;
   assign rl[0] = dispatch.last;
   assign rb[0] = dispatch.block;

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      logic [KEYS_PER_ROUND-1:0][WORD_W-1:0] rk;
      for (genvar j = 0; j < KEYS_PER_ROUND; j++) begin : g_key
         assign rk[j] = key_ff[r * KEYS_PER_ROUND + j];
      end
      idea_enc_round u_round (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .keys      (rk),
         .in_valid  (rv[r]),
         .in_blk    (rb[r]),
         .in_last   (rl[r]),
         .out_valid (rv[r+1]),
         .out_blk   (rb[r+1]),
         .out_last  (rl[r+1]),
         .busy      (rbusy[r])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= '0;
      end else if (en) begin
         ov_ff <= {ov_ff[0], rv[ROUNDS]};
      end
   end

   // output transform: undo the final swap, then reduce
   always_ff @(posedge clock) begin
      if (en) begin
         ol_ff   <= {ol_ff[0], rl[ROUNDS]};
         py0_ff  <= mul_wide(rb[ROUNDS][63:48], key_ff[OutBase]);
         y1_ff   <= rb[ROUNDS][31:16] + key_ff[OutBase + 1];
         y2_ff   <= rb[ROUNDS][47:32] + key_ff[OutBase + 2];
         py3_ff  <= mul_wide(rb[ROUNDS][15:0], key_ff[OutBase + 3]);
         oblk_ff <= {mod_reduce(py0_ff), y1_ff, y2_ff, mod_reduce(py3_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwr_ff  <= 1'b0;
         frd_ff  <= 1'b0;
         fcnt_ff <= 2'd0;
      end else begin
         if (fpush) begin
            fwr_ff <= !fwr_ff;
         end
         if (fpop) begin
            frd_ff <= !frd_ff;
         end
         fcnt_ff <= fcnt_ff + 2'(fpush) - 2'(fpop);
      end
   end

   always_ff @(posedge clock) begin
      if (fpush) begin
         fifo_ff[fwr_ff] <= {ol_ff[1], oblk_ff};
      end
   end

   assign rsp_empty        = (fcnt_ff == 2'd0);
   assign rsp_cipher_block = fifo_ff[frd_ff][BLOCK_W-1:0];
   assign rsp_last_out     = fifo_ff[frd_ff][BLOCK_W];
   assign status.ready     = en;
   assign status.busy      = (|rbusy) || (|ov_ff);

endmodule

// ===== sv/idea_block_encrypt.sv =====
// Top level of the IDEA block encryption engine.
// A load request writes one of the 6*ROUNDS+4 subkeys (slots beyond that are ignored); an
// encrypt request yields one ciphertext block, first word in the top 16 bits. Encrypt
// requests enter one per cycle unless a full result queue stalls the pipeline, and wait in
// the two-entry request and result queues on the way; each round is six pipeline stages, a
// multiply and a reduce for each of its three chained modular multiplications. A load
// waits in the request queue until every block already in the pipeline has finished. No
// subkey is defined after reset: load every slot before the first encrypt.
module idea_block_encrypt
   import idea_enc_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEFAULT
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_command,
   input  logic [INDEX_W-1:0]   req_key_index,
   input  logic [WORD_W-1:0]    req_key_value,
   input  logic [BLOCK_W-1:0]   req_plain_block,
   input  logic                 req_last_block,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [BLOCK_W-1:0]   rsp_cipher_block,
   output logic                 rsp_last_out
);

   dispatch_type    dispatch;
   back_status_type status;

   idea_enc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_key_index   (req_key_index),
      .req_key_value   (req_key_value),
      .req_plain_block (req_plain_block),
      .req_last_block  (req_last_block),
      .status          (status),
      .dispatch        (dispatch)
   );

   idea_enc_back #(.ROUNDS(ROUNDS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .dispatch         (dispatch),
      .status           (status),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_cipher_block (rsp_cipher_block),
      .rsp_last_out     (rsp_last_out)
   );

   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      dispatch.key_wr |-> !status.busy)
      else $error("key load issued with blocks in flight");

   a_issue_when_ready: assert property (@(posedge clock) disable iff (reset)
      dispatch.enc_valid |-> status.ready)
      else $error("block issued into stalled pipeline");

   a_one_issue: assert property (@(posedge clock) disable iff (reset)
      !(dispatch.enc_valid && dispatch.key_wr))
      else $error("load and encrypt issued together");

   a_reset_clear: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule
